// File: hw/rtl/drive_mode_obstacle_fsm_core_defines.svh
// Assertion macros for the drive mode controller RTL.
`ifndef DRIVE_MODE_OBSTACLE_FSM_CORE_DEFINES_SVH
`define DRIVE_MODE_OBSTACLE_FSM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMOF_ASSERT_SAME(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("drive mode controller: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DMOF_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("drive mode controller: next-cycle check failed");

`endif

// File: hw/rtl/dmof_pkg.sv
// Package with codes and types of the drive mode controller.
package dmof_pkg;

    // Drive command codes
    localparam logic [3:0] CMD_NONE  = 4'd0;
    localparam logic [3:0] CMD_STOP  = 4'd1;
    localparam logic [3:0] CMD_FWD   = 4'd2;
    localparam logic [3:0] CMD_REV   = 4'd3;
    localparam logic [3:0] CMD_LEFT  = 4'd4;
    localparam logic [3:0] CMD_RIGHT = 4'd5;
    localparam logic [3:0] CMD_FWD_L = 4'd6;
    localparam logic [3:0] CMD_FWD_R = 4'd7;
    localparam logic [3:0] CMD_REV_L = 4'd8;
    localparam logic [3:0] CMD_REV_R = 4'd9;

    // Drive state codes
    localparam logic [3:0] ST_STOP     = 4'd0;
    localparam logic [3:0] ST_STOP_L   = 4'd1;
    localparam logic [3:0] ST_STOP_R   = 4'd2;
    localparam logic [3:0] ST_FWD      = 4'd3;
    localparam logic [3:0] ST_FWD_L    = 4'd4;
    localparam logic [3:0] ST_FWD_R    = 4'd5;
    localparam logic [3:0] ST_REV      = 4'd6;
    localparam logic [3:0] ST_REV_L    = 4'd7;
    localparam logic [3:0] ST_REV_R    = 4'd8;
    localparam logic [3:0] ST_AVOID    = 4'd9;
    localparam logic [3:0] ST_A_FWD    = 4'd10;
    localparam logic [3:0] ST_A_REV    = 4'd11;
    localparam logic [3:0] ST_A_TURN_L = 4'd12;
    localparam logic [3:0] ST_A_TURN_R = 4'd13;

    // Drive request masks
    localparam logic [5:0] RQ_FWD       = 6'b000001;
    localparam logic [5:0] RQ_REV       = 6'b000010;
    localparam logic [5:0] RQ_STOP      = 6'b000100;
    localparam logic [5:0] RQ_LEFT      = 6'b001000;
    localparam logic [5:0] RQ_RIGHT     = 6'b010000;
    localparam logic [5:0] RQ_STOP_TURN = 6'b100000;

    // Mode request and obstacle bit positions
    localparam int MODE_AUTO_BIT   = 0;
    localparam int MODE_MANUAL_BIT = 1;
    localparam int OBS_LEFT_BIT    = 1;

    // Configuration register indexes
    localparam logic CFG_REVERSE_TICKS = 1'b0;
    localparam logic CFG_TURN_TICKS    = 1'b1;

    // Controller state apart from the tick counter
    typedef struct packed {
        logic       autonomous;
        logic [3:0] drive_state;
        logic       left_tripped;
    } dmof_state_t;

    // Decision of one level: next drive state and command
    typedef struct packed {
        logic [3:0] drive_state;
        logic [3:0] cmd;
    } dmof_dec_t;

endpackage

// File: hw/rtl/dmof_step.sv
// Next-state and command logic for one control tick.
module dmof_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  dmof_pkg::dmof_state_t   state,
    input  logic [COUNT_WIDTH-1:0]  tick_cnt,
    input  logic [15:0]             reverse_ticks,
    input  logic [15:0]             turn_ticks,
    input  logic [1:0]              mode_request,
    input  logic [2:0]              obstacle_bits,
    input  logic [5:0]              drive_request,
    output dmof_pkg::dmof_state_t   state_next,
    output logic [COUNT_WIDTH-1:0]  tick_cnt_next,
    output logic [3:0]              drive_command
);
    import dmof_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CMP_W-1:0]       cnt_ext;
    logic                   rev_done;
    logic                   turn_done;
    logic                   obs_any;
    dmof_dec_t              man_dec;

    // Turn level below a base state that has left and right variants
    function automatic dmof_dec_t turn_level(
        input logic [3:0] st,
        input logic [5:0] req,
        input logic [3:0] base,
        input logic [3:0] base_cmd,
        input logic [3:0] left_cmd,
        input logic [3:0] right_cmd,
        input logic [5:0] leave_mask
    );
        dmof_dec_t d;
        d.drive_state = st;
        if (st == base) begin
            if ((req & RQ_LEFT) != '0) begin
                d = '{base + 4'd1, left_cmd};
            end else if ((req & RQ_RIGHT) != '0) begin
                d = '{base + 4'd2, right_cmd};
            end else begin
                d.cmd = base_cmd;
            end
        end else if ((req & leave_mask) != '0) begin
            d = '{base, base_cmd};
        end else if (st == base + 4'd1) begin
            if ((req & RQ_RIGHT) != '0) begin
                d = '{base + 4'd2, right_cmd};
            end else begin
                d.cmd = left_cmd;
            end
        end else if ((req & RQ_LEFT) != '0) begin
            d = '{base + 4'd1, left_cmd};
        end else begin
            d.cmd = right_cmd;
        end
        return d;
    endfunction

    // Saturating advance, then compare against the timers
    assign cnt_inc   = (tick_cnt == {COUNT_WIDTH{1'b1}}) ? tick_cnt
                                                         : tick_cnt + COUNT_WIDTH'(1);
    assign cnt_ext   = CMP_W'(cnt_inc);
    assign rev_done  = cnt_ext >= CMP_W'(reverse_ticks);
    assign turn_done = cnt_ext >= CMP_W'(turn_ticks);
    assign obs_any   = obstacle_bits != 3'd0;

    // Manual hierarchy: obstacle and stop/fwd/rev first, then turns
    always_comb
    begin
        man_dec = '{state.drive_state, CMD_NONE};
        if (obs_any) begin
            man_dec = '{ST_AVOID, CMD_REV};
        end else if (state.drive_state == ST_AVOID) begin
            man_dec = '{ST_STOP, CMD_STOP};
        end else if (state.drive_state > ST_AVOID) begin
            man_dec = '{state.drive_state, CMD_NONE};
        end else if (state.drive_state <= ST_STOP_R) begin
            if ((drive_request & RQ_FWD) != '0) begin
                man_dec = '{ST_FWD, CMD_FWD};
            end else if ((drive_request & RQ_REV) != '0) begin
                man_dec = '{ST_REV, CMD_REV};
            end else begin
                man_dec = turn_level(state.drive_state, drive_request, ST_STOP, CMD_STOP,
                                     CMD_LEFT, CMD_RIGHT, RQ_STOP | RQ_STOP_TURN);
            end
        end else if (state.drive_state <= ST_FWD_R) begin
            if ((drive_request & RQ_STOP) != '0) begin
                man_dec = '{ST_STOP, CMD_STOP};
            end else if ((drive_request & RQ_REV) != '0) begin
                man_dec = '{ST_REV, CMD_REV};
            end else begin
                man_dec = turn_level(state.drive_state, drive_request, ST_FWD, CMD_FWD,
                                     CMD_FWD_L, CMD_FWD_R, RQ_FWD | RQ_STOP_TURN);
            end
        end else begin
            if ((drive_request & RQ_STOP) != '0) begin
                man_dec = '{ST_STOP, CMD_STOP};
            end else if ((drive_request & RQ_FWD) != '0) begin
                man_dec = '{ST_FWD, CMD_FWD};
            end else begin
                man_dec = turn_level(state.drive_state, drive_request, ST_REV, CMD_REV,
                                     CMD_REV_L, CMD_REV_R, RQ_REV | RQ_STOP_TURN);
            end
        end
    end

    // Mode handling and the auto sequence
    always_comb
    begin
        state_next    = state;
        tick_cnt_next = cnt_inc;
        drive_command = CMD_NONE;
        if (!state.autonomous) begin
            if (mode_request[MODE_AUTO_BIT]) begin
                state_next.autonomous  = 1'b1;
                state_next.drive_state = ST_A_FWD;
                drive_command          = CMD_FWD;
            end else begin
                state_next.drive_state = man_dec.drive_state;
                drive_command          = man_dec.cmd;
            end
        end else if (mode_request[MODE_MANUAL_BIT]) begin
            state_next.autonomous  = 1'b0;
            state_next.drive_state = ST_STOP;
            drive_command          = CMD_STOP;
        end else begin
            unique case (state.drive_state)
                ST_A_FWD:
                begin
                    if (obs_any) begin
                        if (obstacle_bits[OBS_LEFT_BIT]) begin
                            state_next.left_tripped = 1'b1;
                        end
                        state_next.drive_state = ST_A_REV;
                        tick_cnt_next          = '0;
                        drive_command          = CMD_REV;
                    end else begin
                        drive_command = CMD_FWD;
                    end
                end
                ST_A_REV:
                begin
                    if (rev_done) begin
                        tick_cnt_next = '0;
                        if (state.left_tripped) begin
                            state_next.left_tripped = 1'b0;
                            state_next.drive_state  = ST_A_TURN_L;
                            drive_command           = CMD_LEFT;
                        end else begin
                            state_next.drive_state = ST_A_TURN_R;
                            drive_command          = CMD_RIGHT;
                        end
                    end else begin
                        drive_command = CMD_REV;
                    end
                end
                ST_A_TURN_L, ST_A_TURN_R:
                begin
                    if (turn_done) begin
                        if (obs_any) begin
                            state_next.drive_state = ST_A_REV;
                            drive_command          = CMD_REV;
                        end else begin
                            state_next.drive_state = ST_A_FWD;
                            drive_command          = CMD_FWD;
                        end
                    end else begin
                        drive_command = (state.drive_state == ST_A_TURN_L) ? CMD_LEFT
                                                                           : CMD_RIGHT;
                    end
                end
                default:
                begin
                    drive_command = CMD_NONE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/drive_mode_obstacle_fsm_core.sv
// Top level of the drive mode and obstacle avoidance controller.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid / in_ready  | mode_request, obstacle_bits, drive_request
//  output   | out_valid/ out_ready | drive_command, drive_state, auto_active
//  config   | cfg_we               | cfg_index, cfg_data
//
// One input beat is one control tick; a tick is accepted every cycle unless a held result is not taken.
// The tick is decoded against the state registers and the command lands in
// the output register at the edge that accepts the beat.
// The output register is the only buffer: a new beat enters while the held
// result is being taken; with out_ready low and a result held, in_ready drops.
// Reset clears mode, drive state, tick counter, left-trip flag; timers load 20 and 10.
`include "drive_mode_obstacle_fsm_core_defines.svh"

module drive_mode_obstacle_fsm_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // tick input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode_request,
    input  logic [2:0]  obstacle_bits,
    input  logic [5:0]  drive_request,
    // command output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  drive_command,
    output logic [3:0]  drive_state,
    output logic        auto_active,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import dmof_pkg::*;

    dmof_state_t            state_reg;
    dmof_state_t            state_next;
    logic [COUNT_WIDTH-1:0] tick_cnt_reg;
    logic [COUNT_WIDTH-1:0] tick_cnt_next;
    logic [15:0]            reverse_ticks_reg;
    logic [15:0]            turn_ticks_reg;
    logic                   out_valid_reg;
    logic [3:0]             cmd_reg;
    logic [3:0]             dstate_reg;
    logic                   auto_reg;
    logic [3:0]             cmd_next;
    logic                   in_fire;

    // Take a beat whenever the output register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    dmof_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .state         (state_reg),
        .tick_cnt      (tick_cnt_reg),
        .reverse_ticks (reverse_ticks_reg),
        .turn_ticks    (turn_ticks_reg),
        .mode_request  (mode_request),
        .obstacle_bits (obstacle_bits),
        .drive_request (drive_request),
        .state_next    (state_next),
        .tick_cnt_next (tick_cnt_next),
        .drive_command (cmd_next)
    );

    // Advance controller state on every accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= '{1'b0, ST_STOP, 1'b0};
            tick_cnt_reg <= '0;
        end else if (in_fire) begin
            state_reg    <= state_next;
            tick_cnt_reg <= tick_cnt_next;
        end
    end

    // Timer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            reverse_ticks_reg <= 16'd20;
            turn_ticks_reg    <= 16'd10;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_REVERSE_TICKS: reverse_ticks_reg <= cfg_data;
                CFG_TURN_TICKS:    turn_ticks_reg    <= cfg_data;
                default:           reverse_ticks_reg <= reverse_ticks_reg;
            endcase
        end
    end

    // Output valid: set on a new beat, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: hold until the next beat replaces it
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            cmd_reg    <= cmd_next;
            dstate_reg <= state_next.drive_state;
            auto_reg   <= state_next.autonomous;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_command = cmd_reg;
    assign drive_state   = dstate_reg;
    assign auto_active   = auto_reg;

    // Auto mode always sits in one of the auto states
    `DMOF_ASSERT_SAME(a_auto_state, clk, rst_n, state_reg.autonomous,
        state_reg.drive_state >= ST_A_FWD && state_reg.drive_state <= ST_A_TURN_R)
    // Reported mode flag agrees with the reported state
    `DMOF_ASSERT_SAME(a_out_mode, clk, rst_n, out_valid_reg,
        auto_reg == (dstate_reg >= ST_A_FWD))
    // Counter reads zero after a tick only when a timed phase just began
    `DMOF_ASSERT_NEXT(a_cnt_clear, clk, rst_n, in_fire,
        tick_cnt_reg != '0 || state_reg.drive_state == ST_A_REV ||
        state_reg.drive_state == ST_A_TURN_L || state_reg.drive_state == ST_A_TURN_R)

endmodule
